// ===== rtl/srsu_pkg.sv =====
// Shared constants, codes and state encoding for the sorted rank update block.
// No dependencies; compile first.
package srsu_pkg;

    // Table geometry and field widths
    localparam int MAX_IND = 64;
    localparam int IDX_W   = $clog2(MAX_IND);
    localparam int CNT_W   = IDX_W + 1;
    localparam int FIT_W   = 32;

    // Active count limits
    localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_IND);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_IND);

    // Item modes
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SRCH,
        ST_UP_REQ,
        ST_UP_NB,
        ST_UP_CMP,
        ST_DN_REQ,
        ST_DN_NB,
        ST_DN_CMP,
        ST_RD_NB,
        ST_RD_FIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/srsu_if.sv =====
// Valid/ready channel interfaces for items in and results out.
// Depends on srsu_pkg.
interface srsu_in_if;
    import srsu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [IDX_W-1:0]        individual_index;
    logic signed [FIT_W-1:0] new_fitness;
    logic [IDX_W-1:0]        query_position;

    modport source (output valid, mode, individual_index, new_fitness, query_position,
                    input ready);
    modport sink   (input valid, mode, individual_index, new_fitness, query_position,
                    output ready);
endinterface

interface srsu_out_if;
    import srsu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        ranked_individual;
    logic signed [FIT_W-1:0] ranked_fitness;
    logic [IDX_W-1:0]        placed_rank;
    logic                    status;

    modport source (output valid, ranked_individual, ranked_fitness, placed_rank, status,
                    input ready);
    modport sink   (input valid, ranked_individual, ranked_fitness, placed_rank, status,
                    output ready);
endinterface

// ===== rtl/srsu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module srsu_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read (read returns old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sorted_rank_single_update.sv =====
// Top level of the sorted rank update block: sequencer around two RAMs.
// Depends on srsu_pkg, srsu_if (srsu_in_if, srsu_out_if) and srsu_ram.
//
// Keeps a fitness per individual (64 x 32-bit RAM) and a rank table listing
// individuals in ascending fitness order (64 x 6-bit RAM). An update writes the
// new fitness, scans the rank table for the individual (one entry per cycle),
// then bubbles it toward rank 0 past strictly larger neighbors and toward the
// end past strictly smaller ones, each move stepping through rank read,
// fitness read, then compare and write back; each direction ends with a
// failed check. A read fetches the individual at the queried rank, then its
// fitness; an out-of-range item goes straight to an error result.
// Ties keep their order. Reset and every write of active_count run a clearing
// pass over all 64 entries (ranks to identity, fitness to zero) during which
// no item is taken. active_count is clamped to 2..64. A finished result waits
// in an output register, so the next item may be taken before it is collected.
module sorted_rank_single_update (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [srsu_pkg::CNT_W-1:0] cfg_wdata,
    srsu_in_if.sink                    req,
    srsu_out_if.source                 rsp
);
    import srsu_pkg::*;

    // Control registers
    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] active_reg, active_next;
    logic [IDX_W-1:0] clr_reg,    clr_next;
    logic             out_valid_reg, out_valid_next;

    // Working registers
    logic [IDX_W-1:0]        scan_reg, scan_next;
    logic [IDX_W-1:0]        pos_reg,  pos_next;
    logic [IDX_W-1:0]        nb_reg,   nb_next;
    logic [IDX_W-1:0]        idx_reg,  idx_next;
    logic signed [FIT_W-1:0] fit_reg,  fit_next;
    logic                    upd_reg,  upd_next;
    logic                    err_reg,  err_next;

    // Output payload registers
    logic [IDX_W-1:0]        out_ind_reg, out_ind_next;
    logic signed [FIT_W-1:0] out_fit_reg, out_fit_next;
    logic [IDX_W-1:0]        out_pos_reg, out_pos_next;
    logic                    out_st_reg,  out_st_next;

    // RAM ports
    logic             rank_we;
    logic [IDX_W-1:0] rank_waddr, rank_wdata, rank_raddr, rank_rdata;
    logic             fit_we;
    logic [IDX_W-1:0] fit_waddr, fit_raddr;
    logic [FIT_W-1:0] fit_wdata, fit_rdata;

    // Decoded conditions
    logic             in_xfer;
    logic             in_err;
    logic             out_free;
    logic             nb_larger;
    logic             nb_smaller;
    logic             at_last;
    logic             found;

    srsu_ram #(.WIDTH(IDX_W), .DEPTH(MAX_IND)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    srsu_ram #(.WIDTH(FIT_W), .DEPTH(MAX_IND)) u_fit_ram (
        .clk   (clk),
        .we    (fit_we),
        .waddr (fit_waddr),
        .wdata (fit_wdata),
        .raddr (fit_raddr),
        .rdata (fit_rdata)
    );

    // Conditions
    assign in_xfer    = req.valid && req.ready;
    assign in_err     = (req.mode == MODE_UPDATE)
                        ? ({1'b0, req.individual_index} >= active_reg)
                        : ({1'b0, req.query_position} >= active_reg);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign nb_larger  = $signed(fit_rdata) > fit_reg;
    assign nb_smaller = fit_reg > $signed(fit_rdata);
    assign at_last    = ({1'b0, pos_reg} + CNT_W'(1)) >= active_reg;
    assign found      = rank_rdata == idx_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (clr_reg == IDX_W'(MAX_IND - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_err)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (req.mode == MODE_UPDATE)
                    begin
                        state_next = ST_SRCH;
                    end
                    else
                    begin
                        state_next = ST_RD_NB;
                    end
                end
            end
            ST_SRCH:   state_next = found ? ST_UP_REQ : ST_SRCH;
            ST_UP_REQ: state_next = (pos_reg == '0) ? ST_DN_REQ : ST_UP_NB;
            ST_UP_NB:  state_next = ST_UP_CMP;
            ST_UP_CMP: state_next = nb_larger ? ST_UP_REQ : ST_DN_REQ;
            ST_DN_REQ: state_next = at_last ? ST_DONE : ST_DN_NB;
            ST_DN_NB:  state_next = ST_DN_CMP;
            ST_DN_CMP: state_next = nb_smaller ? ST_DN_REQ : ST_DONE;
            ST_RD_NB:  state_next = ST_RD_FIT;
            ST_RD_FIT: state_next = ST_DONE;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_CLR;
        endcase
        // A configuration write restarts the clearing pass
        if (cfg_we)
        begin
            state_next = ST_CLR;
        end
    end

    // RAM controls and input ready
    always_comb
    begin
        req.ready  = 1'b0;
        rank_we    = 1'b0;
        rank_waddr = pos_reg;
        rank_wdata = nb_reg;
        rank_raddr = '0;
        fit_we     = 1'b0;
        fit_waddr  = req.individual_index;
        fit_wdata  = req.new_fitness;
        fit_raddr  = rank_rdata;
        unique case (state_reg)
            ST_CLR:
            begin
                rank_we    = 1'b1;
                rank_waddr = clr_reg;
                rank_wdata = clr_reg;
                fit_we     = 1'b1;
                fit_waddr  = clr_reg;
                fit_wdata  = '0;
            end
            ST_IDLE:
            begin
                req.ready  = 1'b1;
                fit_we     = in_xfer && !in_err && (req.mode == MODE_UPDATE);
                rank_raddr = (req.mode == MODE_UPDATE) ? '0 : req.query_position;
            end
            ST_SRCH:   rank_raddr = scan_reg + IDX_W'(1);
            ST_UP_REQ: rank_raddr = pos_reg - IDX_W'(1);
            ST_UP_CMP: rank_we    = nb_larger;
            ST_DN_REQ: rank_raddr = pos_reg + IDX_W'(1);
            ST_DN_CMP: rank_we    = nb_smaller;
            ST_DONE:
            begin
                // Drop the moved individual into its final slot
                rank_we    = upd_reg && !err_reg;
                rank_wdata = idx_reg;
            end
            ST_UP_NB, ST_DN_NB, ST_RD_NB, ST_RD_FIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Working register updates
    always_comb
    begin
        active_next    = active_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        nb_next        = nb_reg;
        idx_next       = idx_reg;
        fit_next       = fit_reg;
        upd_next       = upd_reg;
        err_next       = err_reg;
        out_ind_next   = out_ind_reg;
        out_fit_next   = out_fit_reg;
        out_pos_next   = out_pos_reg;
        out_st_next    = out_st_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    upd_next  = req.mode == MODE_UPDATE;
                    err_next  = in_err;
                    idx_next  = req.individual_index;
                    fit_next  = req.new_fitness;
                    pos_next  = req.query_position;
                    scan_next = '0;
                end
            end
            ST_SRCH:
            begin
                if (found)
                begin
                    pos_next = scan_reg;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_UP_NB, ST_DN_NB:
            begin
                nb_next = rank_rdata;
            end
            ST_UP_CMP:
            begin
                if (nb_larger)
                begin
                    pos_next = pos_reg - IDX_W'(1);
                end
            end
            ST_DN_CMP:
            begin
                if (nb_smaller)
                begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            ST_RD_NB:
            begin
                idx_next = rank_rdata;
            end
            ST_RD_FIT:
            begin
                fit_next = $signed(fit_rdata);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = err_reg ? STATUS_ERR : STATUS_OK;
                    out_ind_next   = err_reg ? '0 : idx_reg;
                    out_fit_next   = err_reg ? '0 : fit_reg;
                    out_pos_next   = err_reg ? '0 : pos_reg;
                end
            end
            ST_UP_REQ, ST_DN_REQ:
            begin
            end
            default:
            begin
            end
        endcase

        // Active count write with clamping
        if (cfg_we)
        begin
            clr_next = '0;
            priority if (cfg_wdata < CNT_MIN)
            begin
                active_next = CNT_MIN;
            end
            else if (cfg_wdata > CNT_MAX)
            begin
                active_next = CNT_MAX;
            end
            else
            begin
                active_next = cfg_wdata;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            active_reg    <= CNT_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        pos_reg     <= pos_next;
        nb_reg      <= nb_next;
        idx_reg     <= idx_next;
        fit_reg     <= fit_next;
        upd_reg     <= upd_next;
        err_reg     <= err_next;
        out_ind_reg <= out_ind_next;
        out_fit_reg <= out_fit_next;
        out_pos_reg <= out_pos_next;
        out_st_reg  <= out_st_next;
    end

    // Result channel
    assign rsp.valid             = out_valid_reg;
    assign rsp.ranked_individual = out_ind_reg;
    assign rsp.ranked_fitness    = out_fit_reg;
    assign rsp.placed_rank       = out_pos_reg;
    assign rsp.status            = out_st_reg;

    // Checks
    a_ok_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_OK) |-> ({1'b0, rsp.placed_rank} < active_reg))
        else $error("reported rank position beyond active count");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |-> ({1'b0, scan_reg} < active_reg))
        else $error("rank scan ran past active entries");

    a_move_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_CMP || state_reg == ST_DN_CMP) |-> ({1'b0, pos_reg} < active_reg))
        else $error("bubbling position beyond active count");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == ST_CLR && clr_reg == '0))
        else $error("active count write did not start clearing pass");

endmodule
